/* rtl/rhsl_pkg.sv */
// ----------------------------------------------------------------------------
// rhsl_pkg: shared types and constants for the RGB565 HSL window matcher
// Register indexes, widths and the record passed between divider cells.
// ----------------------------------------------------------------------------
package rhsl_pkg;

  localparam int unsigned QW = 8;   // quotient bits (quotients stay below 256)
  localparam int unsigned NW = 17;  // numerator bits (dif*240 < 2^16)
  localparam int unsigned DW = 9;   // divisor bits (up to 511)

  typedef enum logic [2:0] {
    REG_HUE_LOW  = 3'd0,
    REG_HUE_HIGH = 3'd1,
    REG_SAT_LOW  = 3'd2,
    REG_SAT_HIGH = 3'd3,
    REG_LUM_LOW  = 3'd4,
    REG_LUM_HIGH = 3'd5
  } reg_idx_e;

  // One divider lane: restoring division, one quotient bit per cell
  typedef struct packed {
    logic [NW-1:0] rem;   // partial remainder / numerator
    logic [DW-1:0] den;
    logic [QW-1:0] quo;
  } div_lane_t;

  // Payload that travels alongside the divisions
  typedef struct packed {
    logic          vld;
    logic          grey;
    logic          hneg;    // hue quotient is negated
    logic [8:0]    hoff;    // hue offset 0/80/160/240
    logic [7:0]    lum;
    div_lane_t     hdiv;
    div_lane_t     sdiv;
  } cell_t;

endpackage

/* rtl/rhsl_cell.sv */
// ----------------------------------------------------------------------------
// rhsl_cell: one restoring division step for both lanes
// Produces one quotient bit per lane and registers the record for the next cell.
// ----------------------------------------------------------------------------
module rhsl_cell import rhsl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic [2:0] bit_i,
  input  cell_t in_i,
  output cell_t out_o
);

  cell_t c_d, c_q;

  function automatic div_lane_t step(div_lane_t l, logic [2:0] k);
    logic [NW+QW-1:0] sh;
    div_lane_t        o;
    sh = {{QW{1'b0}}, l.den} << k;
    o = l;
    if ({{QW{1'b0}}, l.rem} >= sh) begin
      o.rem    = l.rem - sh[NW-1:0];
      o.quo[k] = 1'b1;
    end
    return o;
  endfunction

  // one quotient bit per lane
  always_comb begin
    c_d      = in_i;
    c_d.hdiv = step(in_i.hdiv, bit_i);
    c_d.sdiv = step(in_i.sdiv, bit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else begin
      c_q <= c_d;
    end
  end

  assign out_o = c_q;

endmodule

/* rtl/rgb565_hsl_color_window_match_top.sv */
// ----------------------------------------------------------------------------
// rgb565_hsl_color_window_match_top: RGB565 to HSL with window match
// Front stage, a chain of eight divider cells, then clamp and compare.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals
// pixel    in         start_i, busy_o, pixel_i
// result   out        done_o, hue_o, saturation_o, luminance_o, matched_o
// config   in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// One pixel per clock; busy_o is always low. The path is one front stage,
// eight divider cells (one quotient bit each) and one output register.
// Reset clears the valid chain and loads the window bounds to 0..240.
// The receiver cannot stall; done_o marks each result for one cycle.
module rgb565_hsl_color_window_match_top import rhsl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] pixel_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  output logic        done_o,
  output logic [7:0]  hue_o,
  output logic [7:0]  saturation_o,
  output logic [7:0]  luminance_o,
  output logic        matched_o
);

  logic [7:0] hue_low_q, hue_high_q, sat_low_q, sat_high_q, lum_low_q, lum_high_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_low_q <= 8'd0; hue_high_q <= 8'd240;
      sat_low_q <= 8'd0; sat_high_q <= 8'd240;
      lum_low_q <= 8'd0; lum_high_q <= 8'd240;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_HUE_LOW:  hue_low_q  <= cfg_data_i;
        REG_HUE_HIGH: hue_high_q <= cfg_data_i;
        REG_SAT_LOW:  sat_low_q  <= cfg_data_i;
        REG_SAT_HIGH: sat_high_q <= cfg_data_i;
        REG_LUM_LOW:  lum_low_q  <= cfg_data_i;
        REG_LUM_HIGH: lum_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // front stage: channels, extremes, luminance, numerators and divisors
  logic [7:0]  r, g, b, mx, mn, dif;
  logic [8:0]  sum;
  logic [24:0] lmul;
  logic [7:0]  lum;
  logic signed [9:0] hnum;
  logic [9:0]  hmag;
  cell_t front_d, front_q;

  always_comb begin
    r  = {pixel_i[15:11], 3'b000};
    g  = {pixel_i[10:5], 2'b00};
    b  = {pixel_i[4:0], 3'b000};
    mx = r; if (g > mx) mx = g; if (b > mx) mx = b;
    mn = r; if (g < mn) mn = g; if (b < mn) mn = b;
    dif  = mx - mn;
    sum  = {1'b0, mx} + {1'b0, mn};
    // sum*240/510 = sum*8/17, reciprocal multiply exact for sum <= 510
    lmul = {16'b0, sum} * 25'd61688;
    lum  = lmul[24:17];
    front_d = '0;
    front_d.vld  = start_i;
    front_d.grey = (dif == 8'd0);
    front_d.lum  = lum;
    if (mx == r) begin
      hnum = $signed({2'b0, g}) - $signed({2'b0, b});
      front_d.hoff = (g < b) ? 9'd240 : 9'd0;
    end else if (mx == g) begin
      hnum = $signed({2'b0, b}) - $signed({2'b0, r});
      front_d.hoff = 9'd80;
    end else begin
      hnum = $signed({2'b0, r}) - $signed({2'b0, g});
      front_d.hoff = 9'd160;
    end
    hmag = hnum[9] ? 10'(-hnum) : 10'(hnum);
    front_d.hneg     = hnum[9];
    front_d.hdiv.rem = {7'b0, hmag} * NW'(40);
    front_d.hdiv.den = {1'b0, dif};
    front_d.sdiv.rem = {9'b0, dif} * NW'(240);
    front_d.sdiv.den = (lum == 8'd0 || lum > 8'd120) ? (9'd511 - sum) : sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) front_q <= '0;
    else         front_q <= front_d;
  end

  // divider chain, MSB quotient bit first
  cell_t chain [QW+1];
  assign chain[0] = front_q;
  for (genvar i = 0; i < QW; i++) begin : g_cell
    rhsl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bit_i  (3'(QW - 1 - i)),
      .in_i   (chain[i]),
      .out_o  (chain[i+1])
    );
  end

  // finish: sign, offset, clamp, compare
  cell_t fin;
  logic signed [10:0] h;
  logic [7:0] hu, sa;
  logic       match_d;
  assign fin = chain[QW];
  always_comb begin
    h  = fin.hneg ? -$signed({3'b0, fin.hdiv.quo}) : $signed({3'b0, fin.hdiv.quo});
    h  = h + $signed({2'b0, fin.hoff});
    if (fin.grey)              hu = 8'd0;
    else if (h < 0)            hu = 8'd0;
    else if (h > 11'sd240)     hu = 8'd240;
    else                       hu = h[7:0];
    if (fin.grey)                 sa = 8'd0;
    else if (fin.sdiv.quo > 8'd240) sa = 8'd240;
    else                          sa = fin.sdiv.quo;
    match_d = hu > hue_low_q && hu < hue_high_q && sa > sat_low_q && sa < sat_high_q &&
              fin.lum > lum_low_q && fin.lum < lum_high_q;
  end

  logic done_q, matched_q;
  logic [7:0] hue_q, sat_q, lum_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= fin.vld;
  end
  always_ff @(posedge clk_i) begin
    hue_q     <= hu;
    sat_q     <= sa;
    lum_q     <= fin.lum;
    matched_q <= match_d;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign luminance_o  = lum_q;
  assign matched_o    = matched_q;

endmodule

/* rtl/rhsl_checker.sv */
// ----------------------------------------------------------------------------
// rhsl_checker: port-level checks for the window matcher
// Latency, output ranges and idle behavior.
// ----------------------------------------------------------------------------
module rhsl_checker import rhsl_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [7:0] hue_o,
  input logic [7:0] saturation_o,
  input logic [7:0] luminance_o
);

  // every accepted start must be followed by done_o
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##10 done_o) else $error("result missing");

  a_nospur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 10)) else $error("spurious result");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> hue_o <= 8'd240 && saturation_o <= 8'd240 && luminance_o <= 8'd240)
    else $error("value out of range");

endmodule

bind rgb565_hsl_color_window_match_top rhsl_checker u_rhsl_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .hue_o(hue_o), .saturation_o(saturation_o),
  .luminance_o(luminance_o)
);
